FILE: rtl/core/tagged_text_word_tokenizer_assert.svh
// Assertion macros shared by the tokenizer RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef TAGGED_TEXT_WORD_TOKENIZER_ASSERT_SVH
`define TAGGED_TEXT_WORD_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define TTWT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TTWT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`else

`define TTWT_ASSERT_IMP(name, clk, rst, ante, cons)

`define TTWT_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/ttwt_pkg.sv
`timescale 1ns / 1ps

package ttwt_pkg;

   // Width of the saturating document counter.
   localparam int DOC_COUNT_BITS = 32;

   // Counter width after extension so it can be compared against the port maximum.
   localparam int CountExtBits = (DOC_COUNT_BITS > 32) ? DOC_COUNT_BITS : 32;

   localparam logic [31:0] DocTotalMax = 32'hFFFF_FFFF;

   // Markup characters.
   localparam logic [7:0] ChTagOpen  = 8'h3C;  // '<'
   localparam logic [7:0] ChTagClose = 8'h3E;  // '>'
   localparam logic [7:0] ChSlash    = 8'h2F;  // '/'
   localparam logic [7:0] ChUpperD   = 8'h44;  // 'D'
   localparam logic [7:0] ChUpperO   = 8'h4F;  // 'O'
   localparam logic [7:0] ChUpperC   = 8'h43;  // 'C'
   localparam logic [7:0] ChUpperN   = 8'h4E;  // 'N'

   typedef struct packed {
      logic        letter_valid;
      logic [6:0]  out_letter;
      logic        word_end;
      logic        doc_end;
      logic [31:0] doc_total;
   } rsp_payload_type;

   // What the parser hands to the output buffer for one byte.
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } parse_result_type;

endpackage

FILE: rtl/core/ttwt_req_if.sv
`timescale 1ns / 1ps

interface ttwt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       line_last;

   modport source (output valid, output in_byte, output line_last, input ready);
   modport sink (input valid, input in_byte, input line_last, output ready);
endinterface

FILE: rtl/core/ttwt_rsp_if.sv
`timescale 1ns / 1ps

interface ttwt_rsp_if;
   logic        valid;
   logic        ready;
   logic        letter_valid;
   logic [6:0]  out_letter;
   logic        word_end;
   logic        doc_end;
   logic [31:0] doc_total;

   modport source (output valid, output letter_valid, output out_letter,
                   output word_end, output doc_end, output doc_total, input ready);
   modport sink (input valid, input letter_valid, input out_letter,
                 input word_end, input doc_end, input doc_total, output ready);
endinterface

FILE: rtl/core/tagged_text_word_tokenizer.sv
`timescale 1ns / 1ps

// Channel   Direction  Transaction contents
// req_bus   in         in_byte (8 bits), line_last (1 bit)
// rsp_bus   out        letter_valid, out_letter (7), word_end, doc_end, doc_total (32)
//
// One byte is accepted per cycle unless a stall on rsp_bus holds it back; a byte is held
// in the input register, then its result, if any, goes to the result register on rsp_bus.
// Bytes that produce no result update the tag and word state and are then dropped.
// Reset is synchronous and clears the tag state, the word state and the document count.
// A stall on rsp_bus holds the result register and, through it, the input register,
// so req_bus.ready falls only while both stages are full and the output is stalled.
module tagged_text_word_tokenizer import ttwt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ttwt_req_if.sink   req_bus,
   ttwt_rsp_if.source rsp_bus
);

   // Input register: holds the accepted byte until the parser can retire it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       line_last_ff;

   logic             out_can_take;
   logic             advance;
   logic             req_fire;
   parse_result_type parse_result;

   // The parser retires the held byte whenever the result register has room for
   // its result, whether or not the byte actually produces one.
   assign advance      = in_valid_ff && out_can_take;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload registers load only on an accepted transaction and need no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff   <= req_bus.in_byte;
         line_last_ff <= req_bus.line_last;
      end
   end

   // Tag matching, word tracking and the document counter.
   ttwt_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .in_byte   (in_byte_ff),
      .line_last (line_last_ff),
      .result    (parse_result)
   );

   // Result register; only bytes that produce a result are loaded into it.
   ttwt_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && parse_result.valid),
      .payload  (parse_result.payload),
      .can_take (out_can_take),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: rtl/core/ttwt_parser.sv
`timescale 1ns / 1ps
`include "tagged_text_word_tokenizer_assert.svh"

// Tag and word state for one byte; state advances only when fire is high.
module ttwt_parser import ttwt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [7:0]       in_byte,
   input  logic             line_last,
   output parse_result_type result
);

   typedef enum logic [2:0] {
      TM_EMPTY = 3'd0,
      TM_D     = 3'd1,
      TM_DO    = 3'd2,
      TM_DOC   = 3'd3,
      TM_DOCN  = 3'd4,
      TM_DOCNO = 3'd5,
      TM_OTHER = 3'd6
   } tag_match_type;

   logic                      in_tag_ff, in_tag_in;
   logic                      in_content_ff, in_content_in;
   logic                      in_docid_ff, in_docid_in;
   logic                      closing_tag_ff, closing_tag_in;
   tag_match_type             tag_match_ff, tag_match_in;
   logic                      word_open_ff, word_open_in;
   logic                      prev_was_open_ff, prev_was_open_in;
   logic [DOC_COUNT_BITS-1:0] doc_counter_ff, doc_counter_in;

   tag_match_type             match_step;
   logic                      is_upper;
   logic                      is_lower;
   logic                      lv, we, de;
   logic [6:0]                letter;
   logic [CountExtBits-1:0]   count_ext;

   // Exact match against DOC and DOCNO, one character per step.
   always_comb begin
      case (tag_match_ff)
         TM_EMPTY: match_step = (in_byte == ChUpperD) ? TM_D     : TM_OTHER;
         TM_D:     match_step = (in_byte == ChUpperO) ? TM_DO    : TM_OTHER;
         TM_DO:    match_step = (in_byte == ChUpperC) ? TM_DOC   : TM_OTHER;
         TM_DOC:   match_step = (in_byte == ChUpperN) ? TM_DOCN  : TM_OTHER;
         TM_DOCN:  match_step = (in_byte == ChUpperO) ? TM_DOCNO : TM_OTHER;
         default:  match_step = TM_OTHER;
      endcase
   end

   assign is_upper = (in_byte >= 8'h41) && (in_byte <= 8'h5A);
   assign is_lower = (in_byte >= 8'h61) && (in_byte <= 8'h7A);

   always_comb begin
      in_tag_in        = in_tag_ff;
      in_content_in    = in_content_ff;
      in_docid_in      = in_docid_ff;
      closing_tag_in   = closing_tag_ff;
      tag_match_in     = tag_match_ff;
      word_open_in     = word_open_ff;
      doc_counter_in   = doc_counter_ff;
      prev_was_open_in = 1'b0;
      lv               = 1'b0;
      we               = 1'b0;
      de               = 1'b0;
      letter           = 7'd0;

      if (in_byte == ChTagOpen) begin
         in_tag_in        = 1'b1;
         in_content_in    = 1'b0;
         we               = word_open_ff;
         word_open_in     = 1'b0;
         prev_was_open_in = !line_last;
      end else if (in_byte == ChTagClose) begin
         in_tag_in     = 1'b0;
         in_content_in = 1'b1;
         we            = word_open_ff;
         word_open_in  = 1'b0;
         if (closing_tag_ff) begin
            if (tag_match_ff == TM_DOCNO) begin
               in_docid_in = 1'b0;
            end else if (tag_match_ff == TM_DOC) begin
               if (doc_counter_ff != {DOC_COUNT_BITS{1'b1}}) begin
                  doc_counter_in = doc_counter_ff + DOC_COUNT_BITS'(1);
               end
               de = 1'b1;
            end
            closing_tag_in = 1'b0;
         end else if (tag_match_ff == TM_DOCNO) begin
            in_docid_in = 1'b1;
         end
         tag_match_in = TM_EMPTY;
      end else if (in_tag_ff) begin
         if ((in_byte == ChSlash) && prev_was_open_ff) begin
            closing_tag_in = 1'b1;
         end else begin
            tag_match_in = match_step;
         end
      end else if (in_content_ff && !in_docid_ff) begin
         if (is_upper || is_lower) begin
            lv           = 1'b1;
            // Setting bit 5 lower-cases an ASCII letter.
            letter       = in_byte[6:0] | 7'h20;
            we           = line_last;
            word_open_in = !line_last;
         end else if (word_open_ff) begin
            we           = 1'b1;
            word_open_in = 1'b0;
         end
      end
   end

   assign count_ext = CountExtBits'(doc_counter_in);

   always_comb begin
      result.valid                = lv || we || de;
      result.payload.letter_valid = lv;
      result.payload.out_letter   = letter;
      result.payload.word_end     = we;
      result.payload.doc_end      = de;
      result.payload.doc_total    = (count_ext > CountExtBits'(DocTotalMax)) ?
                                    DocTotalMax : count_ext[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff        <= 1'b0;
         in_content_ff    <= 1'b0;
         in_docid_ff      <= 1'b0;
         closing_tag_ff   <= 1'b0;
         tag_match_ff     <= TM_EMPTY;
         word_open_ff     <= 1'b0;
         prev_was_open_ff <= 1'b0;
         doc_counter_ff   <= '0;
      end else if (fire) begin
         in_tag_ff        <= in_tag_in;
         in_content_ff    <= in_content_in;
         in_docid_ff      <= in_docid_in;
         closing_tag_ff   <= closing_tag_in;
         tag_match_ff     <= tag_match_in;
         word_open_ff     <= word_open_in;
         prev_was_open_ff <= prev_was_open_in;
         doc_counter_ff   <= doc_counter_in;
      end
   end

   // A slash can only mark a closing tag while a tag is open.
   `TTWT_ASSERT_IMP(a_prev_open_in_tag, clock, reset, prev_was_open_ff, in_tag_ff)
   // An open word only lives in content text outside a tag.
   `TTWT_ASSERT_IMP(a_word_in_content, clock, reset, word_open_ff,
                    in_content_ff && !in_tag_ff)
   // A document end always leaves a nonzero count behind.
   `TTWT_ASSERT_NXT(a_doc_end_counts, clock, reset, fire && de, doc_counter_ff != '0)

endmodule

FILE: rtl/core/ttwt_out_buf.sv
`timescale 1ns / 1ps

// Result register in front of the response channel.
module ttwt_out_buf import ttwt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type payload,
   output logic            can_take,
   ttwt_rsp_if.source      rsp_bus
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   assign can_take = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_take) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_take && load) begin
         data_ff <= payload;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.letter_valid = data_ff.letter_valid;
   assign rsp_bus.out_letter   = data_ff.out_letter;
   assign rsp_bus.word_end     = data_ff.word_end;
   assign rsp_bus.doc_end      = data_ff.doc_end;
   assign rsp_bus.doc_total    = data_ff.doc_total;

endmodule
